@@ sv/assert_macros.svh @@
// Assertion macros used by the packing core of the complex sample packer.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition is never true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ sv/cspk_pkg.sv @@
// Shared constants and types for the complex sample packer.
// Used by the input register, the packing core, the result register and the top level.
package cspk_pkg;

   localparam int COUNT_LIMIT       = 8;
   localparam int IN_SAMPLES        = 8;
   localparam int WORD_SAMPLES      = 16;
   localparam int SAMPLE_W          = 32;
   localparam int COUNT_W           = 4;
   localparam int FILL_W            = 4;
   localparam int ITEM_W            = COUNT_W + IN_SAMPLES * SAMPLE_W;
   localparam int REQ_TDATA_W       = ((ITEM_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W       = WORD_SAMPLES * SAMPLE_W;

   typedef logic [SAMPLE_W-1:0]                  sample_type;
   typedef logic [IN_SAMPLES-1:0][SAMPLE_W-1:0]  in_vec_type;
   typedef logic [WORD_SAMPLES-1:0][SAMPLE_W-1:0] word_type;

   // The count sits in the lowest bits, input sample 0 directly above it.
   typedef struct packed {
      in_vec_type         samples;
      logic [COUNT_W-1:0] valid_count;
   } item_type;

   // Control from the packing core: the held request is consumed, and a word completes.
   typedef struct packed {
      logic take;
      logic emit;
   } pack_ctl_type;

endpackage

@@ sv/complex_sample_packer_core.sv @@
// Gathers up to eight complex samples per request into 16-sample words. One request
// is taken every clock; a completed word is loaded into the result register when the
// held request that completes it is taken, and a word follows every two to sixteen
// requests that carry samples (requests with a zero count are dropped).
// The rate is set by the registered update of the fill level and partial word from the
// input register; the input stalls only while the held request completes a word and the
// full result register is not being taken.
// Depends on cspk_pkg, cspk_in_reg, cspk_pack_core and cspk_out_reg.
module complex_sample_packer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // valid_count [3:0], samples_01 [67:4], samples_23 [131:68], samples_45 [195:132],
   // samples_67 [259:196], zero fill [263:260]
   input  logic [cspk_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_pair_0 [63:0], out_pair_1 [127:64], ... out_pair_7 [511:448]
   output logic [cspk_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cspk_pkg::*;

   pack_ctl_type ctl;
   item_type     item;
   logic         item_valid;
   logic         out_free;
   word_type     result_word;

   cspk_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .ctl        (ctl),
      .item_valid (item_valid),
      .item       (item)
   );

   cspk_pack_core u_pack_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .out_free    (out_free),
      .ctl         (ctl),
      .result_word (result_word)
   );

   cspk_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .result_word (result_word),
      .out_free    (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

@@ sv/cspk_in_reg.sv @@
// Input register of the complex sample packer: holds one request for the packing core.
// Depends on cspk_pkg.
module cspk_in_reg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [cspk_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  cspk_pkg::pack_ctl_type       ctl,
   output logic                         item_valid,
   output cspk_pkg::item_type           item
);
   import cspk_pkg::*;

   logic     item_valid_ff;
   logic     item_valid_in;
   item_type item_ff;
   logic     load;

   assign req_tready = !item_valid_ff || ctl.take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         item_valid_in = 1'b1;
      end else if (ctl.take) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_type'(req_tdata[ITEM_W-1:0]);
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

@@ sv/cspk_pack_core.sv @@
// Packing core of the complex sample packer: fill level, partial word and slot steering.
// Depends on cspk_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cspk_pack_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  cspk_pkg::item_type     item,
   input  logic                   out_free,
   output cspk_pkg::pack_ctl_type ctl,
   output cspk_pkg::word_type     result_word
);
   import cspk_pkg::*;

   logic [FILL_W-1:0]  fill_level_ff;
   logic [FILL_W-1:0]  fill_level_in;
   word_type           partial_word_ff;
   word_type           partial_word_in;
   logic [COUNT_W-1:0] count;
   logic [FILL_W:0]    total;
   logic               complete;
   logic               take;

   always_comb begin
      if (item.valid_count > COUNT_W'(COUNT_LIMIT)) begin
         count = COUNT_W'(COUNT_LIMIT);
      end else begin
         count = item.valid_count;
      end
   end

   assign total    = {1'b0, fill_level_ff} + {1'b0, count};
   assign complete = total[FILL_W];
   assign take     = item_valid && (!complete || out_free);

   assign ctl.take = take;
   assign ctl.emit = take && complete;

   // Slot j takes input sample (j - fill) mod 16, which covers both the append and the carry.
   always_comb begin
      logic [FILL_W-1:0] offset;
      logic              in_range;
      sample_type        smp;
      for (int j = 0; j < WORD_SAMPLES; j++) begin
         offset   = FILL_W'(j) - fill_level_ff;
         in_range = offset < FILL_W'(count);
         smp      = item.samples[offset[2:0]];
         if (FILL_W'(j) >= fill_level_ff) begin
            result_word[j] = smp;
         end else begin
            result_word[j] = partial_word_ff[j];
         end
         if (complete) begin
            partial_word_in[j] = (FILL_W'(j) < total[FILL_W-1:0]) ? smp : '0;
         end else begin
            partial_word_in[j] = in_range ? smp : partial_word_ff[j];
         end
      end
   end

   assign fill_level_in = take ? total[FILL_W-1:0] : fill_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_level_ff <= '0;
      end else begin
         fill_level_ff <= fill_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         partial_word_ff <= partial_word_in;
      end
   end

   `ASSERT_CLK(a_emit_needs_room, ctl.emit |-> out_free, "word completed with result register full")
   `ASSERT_CLK(a_carry_small, ctl.emit |=> fill_level_ff < FILL_W'(COUNT_LIMIT),
               "carry after a completed word exceeds one request")
   `ASSERT_NEVER(a_fill_shrinks, $past(take && !complete) && !$past(reset)
                 && fill_level_ff < $past(fill_level_ff), "fill level dropped without a word")

endmodule

@@ sv/cspk_out_reg.sv @@
// Result register of the complex sample packer: holds one completed 16-sample word.
// Depends on cspk_pkg.
module cspk_out_reg (
   input  logic                             clock,
   input  logic                             reset,
   input  cspk_pkg::pack_ctl_type           ctl,
   input  cspk_pkg::word_type               result_word,
   output logic                             out_free,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cspk_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cspk_pkg::*;

   logic     rsp_tvalid_ff;
   logic     rsp_tvalid_in;
   word_type rsp_word_ff;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      if (ctl.emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_word_ff <= result_word;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_word_ff);

endmodule
